@@ rtl/nwa_pkg.sv @@
// ----------------------------------------------------------------------------
// nwa_pkg
// Shared constants, codes and types of the nearest weight absorber.
// ----------------------------------------------------------------------------
`default_nettype none

package nwa_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int FEATURES_DEF = 8;
    localparam int ID_BITS_DEF  = 20;

    localparam int NUM_SCALE  = 8;
    localparam int FEAT_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int WT_W       = 23;
    localparam int IN_WT_W    = 24;
    localparam int ID_W       = 20;
    localparam int TERM_W     = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int S_DATA_W   = 176;
    localparam int M_DATA_W   = 72;
    localparam int REQ_W      = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [WT_W-1:0]    WT_MAX      = 23'h7FFFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_START  = 2'd0,
        REQ_CAND   = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic start;
        logic insert;
        logic prune;
        logic shift;
        logic clear;
    } list_cmd_t;

endpackage

`default_nettype wire

@@ rtl/nwa_dist_lane.sv @@
// ----------------------------------------------------------------------------
// nwa_dist_lane
// One feature lane: squared difference, then scaled and shifted by 8.
// ----------------------------------------------------------------------------
`default_nettype none

module nwa_dist_lane (
    input  wire logic                        aclk,
    input  wire logic [nwa_pkg::FEAT_W-1:0]  x,
    input  wire logic [nwa_pkg::FEAT_W-1:0]  q,
    input  wire logic [nwa_pkg::SCALE_W-1:0] scale,
    output logic      [nwa_pkg::TERM_W-1:0]  term
);
    import nwa_pkg::*;

    logic signed [FEAT_W:0]      diff;
    logic signed [2*FEAT_W+1:0]  sq_full;
    logic [2*FEAT_W-1:0]         sq_reg;
    logic [2*FEAT_W+SCALE_W-1:0] prod;
    logic [TERM_W-1:0]           term_reg;

    always_comb begin
        diff    = $signed({x[FEAT_W-1], x}) - $signed({q[FEAT_W-1], q});
        sq_full = diff * diff;
        prod    = sq_reg * scale;
    end

    // squares of a 17-bit difference fit in 32 bits
    always_ff @(posedge aclk) begin
        sq_reg   <= sq_full[2*FEAT_W-1:0];
        term_reg <= prod[2*FEAT_W+SCALE_W-1:8];
    end

    assign term = term_reg;

endmodule

`default_nettype wire

@@ rtl/nwa_slot_list.sv @@
// ----------------------------------------------------------------------------
// nwa_slot_list
// Row of sorted slot cells with parallel insert, prefix prune and drain shift.
// ----------------------------------------------------------------------------
`default_nettype none

module nwa_slot_list #(
    parameter int SLOTS   = nwa_pkg::SLOTS_DEF,
    parameter int ID_BITS = nwa_pkg::ID_BITS_DEF,
    parameter int DW      = 43
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire nwa_pkg::list_cmd_t          cmd,
    input  wire logic [DW-1:0]               cand_dist,
    input  wire logic [nwa_pkg::WT_W-1:0]    wt,
    input  wire logic [ID_BITS-1:0]          id,
    input  wire logic [nwa_pkg::WT_W-1:0]    debt,
    output logic      [$clog2(SLOTS+2)-1:0]  count,
    output logic                             ovf,
    output logic      [nwa_pkg::WT_W-1:0]    head_w,
    output logic      [ID_BITS-1:0]          head_id
);
    import nwa_pkg::*;

    localparam int NC = SLOTS + 1;
    localparam int CW = $clog2(SLOTS + 2);
    localparam int SW = WT_W + CW;

    logic [DW-1:0]      dist_reg [NC];
    logic [WT_W-1:0]    w_reg    [NC];
    logic [ID_BITS-1:0] id_reg   [NC];
    logic [SW-1:0]      pre_reg  [NC];
    logic [DW-1:0]      dist_next [NC];
    logic [WT_W-1:0]    w_next    [NC];
    logic [ID_BITS-1:0] id_next   [NC];
    logic [SW-1:0]      pre_next  [NC];

    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] kept_reg, kept_next;
    logic          ovf_reg, ovf_next;

    logic [NC-1:0] lt, lt_prev, keep;
    logic          last_gt, reject;
    logic [SW-1:0] tot, sel_pre;
    logic [CW-1:0] n;

    always_comb begin
        lt      = '0;
        keep    = '0;
        last_gt = 1'b0;
        sel_pre = '0;
        for (int i = 0; i < NC; i++) begin
            lt[i]   = (CW'(i) < count_reg) && (cand_dist < dist_reg[i]);
            keep[i] = (CW'(i) < count_reg) && (pre_reg[i] <= SW'(debt));
            if ((CW'(i + 1) == count_reg) && (cand_dist > dist_reg[i])) begin
                last_gt = 1'b1;
            end
        end
        lt_prev = {lt[NC-2:0], 1'b0};
        tot     = kept_reg + SW'(wt);
        reject  = (count_reg != '0) && last_gt && (tot > SW'(debt));
        n       = CW'($countones(keep));
        for (int i = 0; i < NC; i++) begin
            if (CW'(i) == n) begin
                sel_pre = pre_reg[i];
            end
        end

        for (int i = 0; i < NC; i++) begin
            dist_next[i] = dist_reg[i];
            w_next[i]    = w_reg[i];
            id_next[i]   = id_reg[i];
            pre_next[i]  = pre_reg[i];
        end
        count_next = count_reg;
        kept_next  = kept_reg;
        ovf_next   = ovf_reg;

        if (cmd.start) begin
            count_next = '0;
            kept_next  = '0;
            ovf_next   = 1'b0;
        end else if (cmd.clear) begin
            count_next = '0;
            kept_next  = '0;
        end else if (cmd.insert && !reject) begin
            // entries past the insert point move up one cell
            for (int i = 1; i < NC; i++) begin
                if (lt_prev[i]) begin
                    dist_next[i] = dist_reg[i-1];
                    w_next[i]    = w_reg[i-1];
                    id_next[i]   = id_reg[i-1];
                    pre_next[i]  = pre_reg[i-1] + SW'(wt);
                end
            end
            for (int i = 0; i < NC; i++) begin
                if ((CW'(i) <= count_reg) && !lt_prev[i] &&
                    (lt[i] || (CW'(i) == count_reg))) begin
                    dist_next[i] = cand_dist;
                    w_next[i]    = wt;
                    id_next[i]   = id;
                    pre_next[i]  = (CW'(i) == count_reg) ? kept_reg : pre_reg[i];
                end
            end
            count_next = count_reg + CW'(1);
            kept_next  = tot;
        end else if (cmd.prune) begin
            if (n > CW'(SLOTS)) begin
                count_next = CW'(SLOTS);
                ovf_next   = 1'b1;
                kept_next  = pre_reg[SLOTS];
            end else begin
                count_next = n;
                if (n != count_reg) begin
                    kept_next = sel_pre;
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < NC - 1; i++) begin
                dist_next[i] = dist_reg[i+1];
                w_next[i]    = w_reg[i+1];
                id_next[i]   = id_reg[i+1];
                pre_next[i]  = pre_reg[i+1];
            end
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NC; i++) begin
            dist_reg[i] <= dist_next[i];
            w_reg[i]    <= w_next[i];
            id_reg[i]   <= id_next[i];
            pre_reg[i]  <= pre_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            kept_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            kept_reg  <= kept_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign count   = count_reg;
    assign ovf     = ovf_reg;
    assign head_w  = w_reg[0];
    assign head_id = id_reg[0];

endmodule

`default_nettype wire

@@ rtl/nearest_weight_absorber_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_weight_absorber_unit
// Absorbs a negative query weight into the nearest positive candidates.
// ----------------------------------------------------------------------------
// start item: loads the query and debt on accept. candidate item: accept, two multiply
//   stages per feature lane, distance sum, parallel insert across the slot cells,
//   prefix prune; ends at accept when its weight is not positive; one item in flight.
// finish item: at most slot count + 1 results, one per cycle while m_tready is high.
// reset: synchronous active-low aresetn clears control, list and scales.
`default_nettype none

module nearest_weight_absorber_unit #(
    parameter int SLOTS    = nwa_pkg::SLOTS_DEF,
    parameter int FEATURES = nwa_pkg::FEATURES_DEF,
    parameter int ID_BITS  = nwa_pkg::ID_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // event_id[19:0], weight[43:20], feature_0..feature_7 16 bits each from 44
    input  wire logic [nwa_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [nwa_pkg::REQ_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // taken_id[19:0], new_weight[42:20], leftover[65:43], overflowed[66]
    output logic      [nwa_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nwa_pkg::SCALE_W-1:0]   cfg_data
);
    import nwa_pkg::*;

    localparam int DW = TERM_W + $clog2(FEATURES + 1);
    localparam int CW = $clog2(SLOTS + 2);
    localparam int KB = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_D1   = 7'b0000010,
        ST_D2   = 7'b0000100,
        ST_D3   = 7'b0001000,
        ST_INS  = 7'b0010000,
        ST_PRN  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_reg [NUM_SCALE];
    logic [FEAT_W-1:0]  query_reg [FEATURES];
    logic [FEAT_W-1:0]  feat_reg  [FEATURES];
    logic [WT_W-1:0]    debt_reg, debt_next;
    logic [WT_W-1:0]    rem_reg, rem_next;
    logic [WT_W-1:0]    wt_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [DW-1:0]      dist_reg;
    logic               sum_pend_reg, sum_pend_next;

    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic [TERM_W-1:0]  term [FEATURES];
    logic [DW-1:0]      dist_sum;

    logic                     s_fire, out_free;
    req_t                     req;
    logic signed [IN_WT_W-1:0] w_in;
    logic [IN_WT_W:0]          neg_w;
    logic [WT_W-1:0]           start_debt;
    logic [ID_BITS-1:0]        id_in;
    logic [ID_W-1:0]           id_out;

    list_cmd_t              cmd;
    logic [CW-1:0]          count;
    logic                   ovf;
    logic [WT_W-1:0]        head_w;
    logic [ID_BITS-1:0]     head_id;

    for (genvar f = 0; f < FEATURES; f++) begin : g_lane
        nwa_dist_lane u_lane (
            .aclk  (aclk),
            .x     (feat_reg[f]),
            .q     (query_reg[f]),
            .scale (scale_reg[f]),
            .term  (term[f])
        );
    end

    nwa_slot_list #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS),
        .DW      (DW)
    ) u_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cand_dist (dist_reg),
        .wt        (wt_reg),
        .id        (id_reg),
        .debt      (debt_reg),
        .count     (count),
        .ovf       (ovf),
        .head_w    (head_w),
        .head_id   (head_id)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        req   = req_t'(s_tuser);
        w_in  = $signed(s_tdata[43:20]);
        neg_w = (IN_WT_W + 1)'(0) - {w_in[IN_WT_W-1], w_in};
        if (!w_in[IN_WT_W-1]) begin
            start_debt = '0;
        end else if (neg_w > (IN_WT_W + 1)'(WT_MAX)) begin
            start_debt = WT_MAX;
        end else begin
            start_debt = neg_w[WT_W-1:0];
        end
        id_in          = '0;
        id_in[KB-1:0]  = s_tdata[KB-1:0];
        id_out         = '0;
        id_out[KB-1:0] = head_id[KB-1:0];
        dist_sum = '0;
        for (int f = 0; f < FEATURES; f++) begin
            dist_sum = dist_sum + DW'(term[f]);
        end
    end

    always_comb begin
        state_next    = state_reg;
        debt_next     = debt_reg;
        rem_next      = rem_reg;
        sum_pend_next = sum_pend_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (req)
                        REQ_START: begin
                            cmd.start = 1'b1;
                            debt_next = start_debt;
                        end
                        REQ_CAND: begin
                            if (!w_in[IN_WT_W-1] && (w_in != '0)) begin
                                state_next = ST_D1;
                            end
                        end
                        REQ_FINISH: begin
                            rem_next      = debt_reg;
                            sum_pend_next = 1'b0;
                            state_next    = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_D1:  state_next = ST_D2;
            ST_D2:  state_next = ST_D3;
            ST_D3:  state_next = ST_INS;
            ST_INS: begin
                cmd.insert = 1'b1;
                state_next = ST_PRN;
            end
            ST_PRN: begin
                cmd.prune  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sum_pend_reg || (count == '0)) begin
                        // summary transfer closes the run
                        m_data_next = {(M_DATA_W - 67)'(0), ovf, rem_reg,
                                       WT_W'(0), ID_W'(0)};
                        m_last_next = 1'b1;
                        cmd.clear   = 1'b1;
                        debt_next   = rem_reg;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.shift   = 1'b1;
                        m_last_next = 1'b0;
                        if (rem_reg > head_w) begin
                            m_data_next = {(M_DATA_W - 67)'(0), ovf, WT_W'(0),
                                           WT_W'(0), id_out};
                            rem_next    = rem_reg - head_w;
                        end else begin
                            m_data_next = {(M_DATA_W - 67)'(0), ovf, WT_W'(0),
                                           WT_W'(head_w - rem_reg), id_out};
                            rem_next      = '0;
                            sum_pend_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            debt_reg     <= '0;
            m_valid_reg  <= 1'b0;
            sum_pend_reg <= 1'b0;
            for (int i = 0; i < NUM_SCALE; i++) begin
                scale_reg[i] <= SCALE_RESET;
            end
            for (int f = 0; f < FEATURES; f++) begin
                query_reg[f] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            debt_reg     <= debt_next;
            m_valid_reg  <= m_valid_next;
            sum_pend_reg <= sum_pend_next;
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_SCALE))) begin
                scale_reg[cfg_index[2:0]] <= cfg_data;
            end
            if (s_fire && (req == REQ_START)) begin
                for (int f = 0; f < FEATURES; f++) begin
                    query_reg[f] <= s_tdata[44 + FEAT_W*f +: FEAT_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        if (state_reg == ST_D3) begin
            dist_reg <= dist_sum;
        end
        if (s_fire) begin
            wt_reg <= w_in[WT_W-1:0];
            id_reg <= id_in;
            for (int f = 0; f < FEATURES; f++) begin
                feat_reg[f] <= s_tdata[44 + FEAT_W*f +: FEAT_W];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count <= CW'(SLOTS)))
        else $error("slot count above capacity while idle");

    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> ((m_tdata[19:0] == '0) && (m_tdata[42:20] == '0)))
        else $error("summary transfer carries an event or weight");

    a_entry_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[65:43] == '0))
        else $error("entry transfer carries leftover");

    a_prune_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRN) |=> (state_reg == ST_IDLE))
        else $error("candidate did not finish after prune");

endmodule

`default_nettype wire

@@ tb/nearest_weight_absorber_unit_test.sv @@
// ----------------------------------------------------------------------------
// nearest_weight_absorber_unit_test
// Drives start, candidate and finish transfers through the absorber under
// three idling phases with different scale settings. A scoreboard keeps its
// own sorted candidate list and checks every drained result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [19:0] taken_id;
    logic [22:0] new_weight;
    logic [22:0] leftover;
    logic        overflowed;
    logic        last;
} absorb_result_t;

class absorb_scoreboard;
    logic [15:0]       scale[8];
    longint            query[8];
    longint unsigned   debt;
    longint unsigned   dist_list[33];
    longint unsigned   weight_list[33];
    logic [19:0]       event_list[33];
    int                count;
    longint unsigned   kept_sum;
    bit                overflow;
    absorb_result_t    pending[$];
    int                errors;
    int                results;

    function new();
        for (int f = 0; f < 8; f++) begin
            scale[f] = nwa_pkg::SCALE_RESET;
            query[f] = 0;
        end
        debt = 0;
        count = 0;
        kept_sum = 0;
        overflow = 0;
        errors = 0;
        results = 0;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function void add_result(logic [19:0] id, longint unsigned nw, longint unsigned left,
                             bit last);
        absorb_result_t r;
        r.taken_id = id;
        r.new_weight = nw[22:0];
        r.leftover = left[22:0];
        r.overflowed = overflow;
        r.last = last;
        pending = {pending, r};
    endfunction

    // updates the list model for one accepted input transfer
    function void note_input(nwa_pkg::req_t req, logic [175:0] data);
        longint w;
        longint unsigned cand_dist, sum, rem, d2;
        longint d;
        int k, n, i;
        w = longint'($signed(data[43:20]));
        if (req == nwa_pkg::REQ_START) begin
            for (int f = 0; f < 8; f++)
                query[f] = longint'($signed(data[44+16*f +: 16]));
            if (w < 0)
                debt = (-w > 64'h7FFFFF) ? 64'h7FFFFF : -w;
            else
                debt = 0;
            count = 0;
            kept_sum = 0;
            overflow = 0;
        end else if (req == nwa_pkg::REQ_CAND) begin
            if (w <= 0)
                return;
            cand_dist = 0;
            for (int f = 0; f < 8; f++) begin
                d = longint'($signed(data[44+16*f +: 16])) - query[f];
                d2 = d * d;
                cand_dist += (d2 * scale[f]) >> 8;
            end
            cand_dist &= 64'hFFFF_FFFF_FFFF;
            if (count > 0 && cand_dist > dist_list[count-1] && kept_sum + w > debt)
                return;
            for (k = 0; k < count; k++)
                if (cand_dist < dist_list[k])
                    break;
            for (i = count; i > k; i--) begin
                dist_list[i] = dist_list[i-1];
                weight_list[i] = weight_list[i-1];
                event_list[i] = event_list[i-1];
            end
            dist_list[k] = cand_dist;
            weight_list[k] = w;
            event_list[k] = data[19:0];
            n = count + 1;
            sum = 0;
            for (i = 0; i < n; i++) begin
                if (sum > debt)
                    break;
                sum += weight_list[i];
            end
            n = i;
            // list full: farthest entry falls off
            if (n > 32) begin
                n = 32;
                overflow = 1;
                sum = 0;
                for (i = 0; i < n; i++)
                    sum += weight_list[i];
            end
            count = n;
            kept_sum = sum;
        end else if (req == nwa_pkg::REQ_FINISH) begin
            rem = debt;
            for (k = 0; k < count; k++) begin
                if (rem > weight_list[k]) begin
                    rem -= weight_list[k];
                    add_result(event_list[k], 0, 0, 0);
                end else begin
                    add_result(event_list[k], weight_list[k] - rem, 0, 0);
                    rem = 0;
                    break;
                end
            end
            add_result(0, 0, rem, 1);
            count = 0;
            kept_sum = 0;
            debt = rem;
        end
    endfunction

    task check_result(logic [71:0] data, logic last);
        absorb_result_t e;
        results++;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result %h last %0b", data, last));
            return;
        end
        e = pending.pop_front();
        if (data[19:0] !== e.taken_id)
            report($sformatf("taken_id %h expected %h", data[19:0], e.taken_id));
        if (data[42:20] !== e.new_weight)
            report($sformatf("new_weight %h expected %h", data[42:20], e.new_weight));
        if (data[65:43] !== e.leftover)
            report($sformatf("leftover %h expected %h", data[65:43], e.leftover));
        if (data[66] !== e.overflowed)
            report($sformatf("overflowed %b expected %b", data[66], e.overflowed));
        if (last !== e.last)
            report($sformatf("last %b expected %b", last, e.last));
    endtask
endclass

module nearest_weight_absorber_unit_test;
    import nwa_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;

    absorb_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  idle_cycles;
    int  n_start, n_cand, n_finish, n_items;
    logic [15:0] query_ref[8];

    nearest_weight_absorber_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAIL nearest_weight_absorber_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(req_t req, logic [19:0] id, logic [23:0] w, logic [15:0] f[8]);
        logic [175:0] data;
        data = '0;
        data[19:0] = id;
        data[43:20] = w;
        for (int i = 0; i < 8; i++)
            data[44+16*i +: 16] = f[i];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= req;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, data);
        n_items++;
        if (req == REQ_START) n_start++;
        if (req == REQ_CAND) n_cand++;
        if (req == REQ_FINISH) n_finish++;
        @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_scale(int idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.scale[idx] = value;
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic start_query(logic [23:0] w);
        logic [15:0] f[8];
        for (int i = 0; i < 8; i++) begin
            f[i] = 16'($urandom);
            query_ref[i] = f[i];
        end
        send_item(REQ_START, 20'($urandom), w, f);
    endtask

    // candidate near the current query, or anywhere when far is set
    task automatic send_cand(logic [19:0] id, logic [23:0] w, bit far);
        logic [15:0] f[8];
        for (int i = 0; i < 8; i++)
            f[i] = far ? 16'($urandom) : query_ref[i] + 16'($urandom_range(0, 64)) - 16'd32;
        send_item(REQ_CAND, id, w, f);
    endtask

    task automatic send_ctrl(req_t req);
        logic [15:0] f[8];
        for (int i = 0; i < 8; i++)
            f[i] = 16'($urandom);
        send_item(req, 20'($urandom), 24'($urandom), f);
    endtask

    task automatic directed_part();
        logic [15:0] hi[8];
        logic [15:0] lo[8];
        for (int i = 0; i < 8; i++) begin
            hi[i] = 16'h7FFF;
            lo[i] = 16'h8000;
        end
        // debt saturation, extreme features and weights
        send_item(REQ_START, 20'hFFFFF, 24'h800000, lo);
        send_item(REQ_CAND, 20'hFFFFF, 24'h7FFFFF, hi);
        send_item(REQ_CAND, 20'h00001, 24'h000001, lo);
        send_item(REQ_CAND, 20'h00002, 24'h000000, lo);
        send_item(REQ_CAND, 20'h00003, 24'h800000, lo);
        send_item(REQ_NONE, 20'h00004, 24'h000100, lo);
        send_item(REQ_FINISH, 20'h0, 24'h0, lo);
        // finish with nothing listed, debt carried over
        send_item(REQ_FINISH, 20'h0, 24'h0, lo);
        // ties, then a far heavy candidate that must be rejected
        send_item(REQ_START, 20'h0, -24'sd1000, hi);
        send_item(REQ_CAND, 20'h00010, 24'd300, hi);
        send_item(REQ_CAND, 20'h00011, 24'd400, hi);
        send_item(REQ_CAND, 20'h00012, 24'd5000, lo);
        send_item(REQ_CAND, 20'h00013, 24'd200, hi);
        send_item(REQ_FINISH, 20'h0, 24'h0, lo);
        // zero debt from a positive start weight
        send_item(REQ_START, 20'h0, 24'd77, hi);
        send_item(REQ_CAND, 20'h00020, 24'd50, lo);
        send_item(REQ_FINISH, 20'h0, 24'h0, lo);
    endtask

    task automatic random_part(int items_target);
        int kind, ncand;
        logic [23:0] w;
        while (n_items < items_target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // tiny weights under the largest debt fill the list past its size
                start_query(24'h800000);
                ncand = $urandom_range(33, 36);
                for (int c = 0; c < ncand; c++)
                    send_cand(20'($urandom), 24'($urandom_range(1, 2000)),
                              $urandom_range(0, 1) == 1);
            end else begin
                start_query(-24'($urandom_range(0, 200000)));
                ncand = $urandom_range(0, 8);
                for (int c = 0; c < ncand; c++) begin
                    case ($urandom_range(0, 9))
                        0: w = 24'($urandom);
                        1: w = -24'($urandom_range(0, 100));
                        default: w = 24'($urandom_range(1, 60000));
                    endcase
                    send_cand(20'($urandom), w, $urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 9) == 0)
                    send_ctrl(REQ_NONE);
            end
            send_ctrl(REQ_FINISH);
            if ($urandom_range(0, 7) == 0)
                send_ctrl(REQ_FINISH);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 14;
        recv_stall_pct = 55;
        n_start = 0;
        n_cand = 0;
        n_finish = 0;
        n_items = 0;
        for (int i = 0; i < 8; i++)
            query_ref[i] = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_SCALE; i++)
            write_scale(i, 16'($urandom_range(0, 1024)));
        cfg_valid <= 1'b0;
        directed_part();
        random_part(65);
        wait_quiet();

        send_idle_pct = 55;
        recv_stall_pct = 14;
        for (int i = 0; i < NUM_SCALE; i++)
            write_scale(i, (i % 2) ? 16'hFFFF : 16'h0000);
        cfg_valid <= 1'b0;
        random_part(110);
        wait_quiet();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_SCALE; i++)
            write_scale(i, 16'($urandom));
        cfg_valid <= 1'b0;
        random_part(160);
        wait_quiet();

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("covered %0d starts, %0d candidates, %0d finishes, %0d results checked",
                 n_start, n_cand, n_finish, sb.results);
        $display("three idling phases, scales at random values, zero and full scale");
        if (sb.errors == 0) begin
            $display("PASS nearest_weight_absorber_unit");
        end else begin
            $display("FAIL nearest_weight_absorber_unit");
        end
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nwa_pkg.sv
rtl/nwa_dist_lane.sv
rtl/nwa_slot_list.sv
rtl/nearest_weight_absorber_unit.sv
tb/nearest_weight_absorber_unit_test.sv
